// File: hdl/kus_pkg.sv
`timescale 1ns / 1ps

package kus_pkg;

  localparam int DEPTH  = 16;
  localparam int KEY_W  = 32;
  localparam int VAL_W  = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int OCC_W  = $clog2(DEPTH + 1);

  // stream widths, padded to whole bytes
  localparam int S_DATA_W = ((KEY_W + VAL_W + 7) / 8) * 8;
  localparam int M_DATA_W = ((KEY_W + VAL_W + OCC_W + 7) / 8) * 8;

  // func codes; code 3 is a no-op
  localparam logic [1:0] FUNC_PUSH = 2'd0;
  localparam logic [1:0] FUNC_POP  = 2'd1;
  localparam logic [1:0] FUNC_PEEK = 2'd2;

  // status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_DUP   = 2'd1;
  localparam logic [1:0] STAT_UNDER = 2'd2;
  localparam logic [1:0] STAT_OVER  = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_TOP,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [1:0]       func;
    logic [KEY_W-1:0] item_key;
    logic [VAL_W-1:0] item_value;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [KEY_W-1:0] top_key;
    logic [VAL_W-1:0] top_value;
    logic [OCC_W-1:0] occupancy;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [KEY_W-1:0]  wkey;
    logic [VAL_W-1:0]  wval;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

// File: hdl/kus_store.sv
`timescale 1ns / 1ps

module kus_store
  import kus_pkg::*;
(
  input  logic             clk,
  input  mem_req_t         mreq,
  output logic [KEY_W-1:0] rkey,
  output logic [VAL_W-1:0] rval
);

  logic [KEY_W-1:0] key_mem [DEPTH];
  logic [VAL_W-1:0] val_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (mreq.we) begin
      key_mem[mreq.waddr] <= mreq.wkey;
      val_mem[mreq.waddr] <= mreq.wval;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rkey <= key_mem[mreq.raddr];
    rval <= val_mem[mreq.raddr];
  end

endmodule

// File: hdl/kus_seq.sv
`timescale 1ns / 1ps

module kus_seq
  import kus_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  req_t             req,
  input  logic             out_free,
  input  logic [KEY_W-1:0] rkey,
  input  logic [VAL_W-1:0] rval,
  output logic             ready,
  output mem_req_t         mreq,
  output logic             res_valid,
  output res_t             res
);

  state_t           state, state_next;
  logic [OCC_W-1:0] fill;
  logic [OCC_W-1:0] idx;
  logic             cmp_v;
  req_t             cur;

  logic hit;
  logic scan_done;
  logic full;

  // single key comparator, fed by the scan read port
  assign hit       = cmp_v && (rkey == cur.item_key);
  assign scan_done = (idx == fill) && !cmp_v;
  assign full      = (fill == OCC_W'(DEPTH));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          case (req.func)
            FUNC_PUSH:           state_next = S_SCAN;
            FUNC_POP, FUNC_PEEK: state_next = (fill == '0) ? S_RESP : S_TOP;
            default:             state_next = S_RESP;
          endcase
        end
      end
      S_SCAN: begin
        if (hit || scan_done) state_next = S_RESP;
      end
      S_TOP: state_next = S_RESP;
      S_RESP: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ready      = (state == S_IDLE);
    res_valid  = (state == S_RESP) && out_free;
    mreq.we    = (state == S_SCAN) && scan_done && !full;
    mreq.waddr = fill[ADDR_W-1:0];
    mreq.wkey  = cur.item_key;
    mreq.wval  = cur.item_value;
    // idle: prefetch the top slot; scan: walk the slots
    mreq.raddr = (state == S_SCAN) ? idx[ADDR_W-1:0] : ADDR_W'(fill - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
      cmp_v <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          cmp_v <= 1'b0;
          if (start) begin
            cur           <= req;
            idx           <= '0;
            res.status    <= STAT_OK;
            res.top_key   <= '0;
            res.top_value <= '0;
            res.occupancy <= fill;
            if ((req.func == FUNC_POP || req.func == FUNC_PEEK) && fill == '0) begin
              res.status <= STAT_UNDER;
            end
          end
        end
        S_SCAN: begin
          if (idx != fill) begin
            idx   <= idx + 1'b1;
            cmp_v <= 1'b1;
          end else begin
            cmp_v <= 1'b0;
          end
          if (hit) begin
            res.status <= STAT_DUP;
          end else if (scan_done) begin
            if (full) begin
              res.status <= STAT_OVER;
            end else begin
              fill          <= fill + 1'b1;
              res.occupancy <= fill + 1'b1;
            end
          end
        end
        S_TOP: begin
          res.top_key   <= rkey;
          res.top_value <= rval;
          if (cur.func == FUNC_POP) begin
            fill          <= fill - 1'b1;
            res.occupancy <= fill - 1'b1;
          end
        end
        S_RESP: begin
          cmp_v <= 1'b0;
        end
        default: begin
          cmp_v <= 1'b0;
        end
      endcase
    end
  end

endmodule

// File: hdl/keyed_unique_stack_top.sv
`timescale 1ns / 1ps
// Keyed unique stack: LIFO of key/value pairs, push rejects a key already held.
// Push: the new key is compared against each entry held, then written if the stack is not full;
//   one stored key per cycle through one comparator, a duplicate stops the scan early.
// Pop, peek: accept, top read, result load; underflow and no-op skip the top read.
// m_tvalid rises with the result load; a held result stalls the next load.
// Reset (rst, synchronous, active high) empties the stack; store is not cleared.

module keyed_unique_stack_top
  import kus_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // input items
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // item_key, item_value
  input  logic [1:0]          s_tuser,   // func
  // result items
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,   // top_key, top_value, occupancy, zero pad
  output logic [1:0]          m_tuser    // status
);

  req_t             req;
  res_t             res;
  res_t             out_res;
  mem_req_t         mreq;
  logic             start;
  logic             out_free;
  logic             res_valid;
  logic [KEY_W-1:0] rkey;
  logic [VAL_W-1:0] rval;

  assign start          = s_tvalid && s_tready;
  assign req.func       = s_tuser;
  assign req.item_key   = s_tdata[KEY_W-1:0];
  assign req.item_value = s_tdata[KEY_W+VAL_W-1:KEY_W];

  // output register frees when empty or being taken this cycle
  assign out_free = !m_tvalid || m_tready;

  kus_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (req),
    .out_free  (out_free),
    .rkey      (rkey),
    .rval      (rval),
    .ready     (s_tready),
    .mreq      (mreq),
    .res_valid (res_valid),
    .res       (res)
  );

  kus_store u_store (
    .clk  (clk),
    .mreq (mreq),
    .rkey (rkey),
    .rval (rval)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res <= res;
    end
  end

  assign m_tuser = out_res.status;
  assign m_tdata = M_DATA_W'({out_res.occupancy, out_res.top_value, out_res.top_key});

endmodule
